[rtl/sctok_pkg.sv]
// shared types, character codes and constants for the source character tokenizer
`timescale 1ns / 1ps
`default_nettype none

package sctok_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 12;

  // results one item can cause at most
  localparam int MAX_RES      = 4;
  localparam int RES_IDX_BITS = $clog2(MAX_RES);
  localparam int RES_CNT_BITS = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [3:0] {
    M_IDLE,
    M_NUM,
    M_IDENT,
    M_OP1,
    M_OP2,
    M_COMMENT,
    M_STRING,
    M_CHAR1,
    M_CHAR2
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_NUMBER,
    KIND_IDENT,
    KIND_SYMBOL,
    KIND_STRING,
    KIND_CHAR,
    KIND_END
  } tok_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_SECOND_DOT,
    ERR_TRAILING_DOT,
    ERR_UNTERMINATED,
    ERR_INVALID
  } tok_err_t;

  // scanner state apart from positions
  typedef struct packed {
    scan_mode_t mode;
    logic       dot_seen;
    logic       held_first;
    logic       held_err;
    logic [7:0] pend0;
    logic [7:0] pend1;
  } scan_state_t;

  // one result apart from its position
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] chr;
    logic       first;
    logic       last;
    tok_err_t   err;
  } tok_info_t;

  function automatic tok_info_t mk_info(input tok_kind_t kind, input logic [7:0] chr,
                                        input logic first, input logic last,
                                        input tok_err_t err);
    tok_info_t r;
    r.kind  = kind;
    r.chr   = chr;
    r.first = first;
    r.last  = last;
    r.err   = err;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sctok_if.sv]
// valid/ready channel interfaces for source bytes and token results
`timescale 1ns / 1ps
`default_nettype none

interface sctok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface sctok_out_if #(
  parameter int LINE_BITS   = sctok_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = sctok_pkg::COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [7:0]             token_byte;
  logic                   token_first;
  logic                   token_last;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;
  logic [2:0]             error_code;
  logic                   run_last;

  modport source (
    output valid, output token_kind, output token_byte, output token_first,
    output token_last, output line_number, output column_number, output error_code,
    output run_last, input ready
  );
  modport sink (
    input valid, input token_kind, input token_byte, input token_first,
    input token_last, input line_number, input column_number, input error_code,
    input run_last, output ready
  );
endinterface

`default_nettype wire

[rtl/sctok_step.sv]
// next-state and result logic of the scanner for one source byte
`timescale 1ns / 1ps
`default_nettype none

module sctok_step #(
  parameter int LINE_BITS   = sctok_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = sctok_pkg::COLUMN_BITS_DEF
) (
  input  logic [7:0]              b,
  input  logic                    fin,
  input  sctok_pkg::scan_state_t  st,
  input  logic [LINE_BITS-1:0]    ln,
  input  logic [COLUMN_BITS-1:0]  cl,
  input  logic [LINE_BITS-1:0]    hln0,
  input  logic [COLUMN_BITS-1:0]  hcl0,
  input  logic [LINE_BITS-1:0]    hln1,
  input  logic [COLUMN_BITS-1:0]  hcl1,
  output sctok_pkg::scan_state_t  st_nxt,
  output logic [LINE_BITS-1:0]    ln_nxt,
  output logic [COLUMN_BITS-1:0]  cl_nxt,
  output logic [LINE_BITS-1:0]    hln0_nxt,
  output logic [COLUMN_BITS-1:0]  hcl0_nxt,
  output logic [LINE_BITS-1:0]    hln1_nxt,
  output logic [COLUMN_BITS-1:0]  hcl1_nxt,
  output sctok_pkg::tok_info_t    info [sctok_pkg::MAX_RES],
  output logic [LINE_BITS-1:0]    rec_ln [sctok_pkg::MAX_RES],
  output logic [COLUMN_BITS-1:0]  rec_cl [sctok_pkg::MAX_RES],
  output logic [sctok_pkg::RES_CNT_BITS-1:0] n
);
  import sctok_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_opchar(input logic [7:0] c);
    return c == CH_EQ || c == CH_LT || c == CH_GT || c == 8'h21 || c == CH_PLUS ||
           c == CH_MINUS || c == 8'h2a || c == CH_SLASH || c == 8'h25;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h2c || c == 8'h7b || c == 8'h7d ||
           c == 8'h5b || c == 8'h5d || c == 8'h3a || c == 8'h3f || c == 8'h3b;
  endfunction

  function automatic logic [LINE_BITS-1:0] sat_ln(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic logic [COLUMN_BITS-1:0] sat_cl(input logic [COLUMN_BITS-1:0] v);
    return (&v) ? v : v + COLUMN_BITS'(1);
  endfunction

  function automatic tok_err_t close_err(input logic num, input logic held_err,
                                         input logic [7:0] c);
    if (held_err) return ERR_SECOND_DOT;
    if (num && c == CH_DOT) return ERR_TRAILING_DOT;
    return ERR_NONE;
  endfunction

  logic                    is_num;
  logic                    cont;
  logic                    do_begin;
  logic [7:0]              p;
  logic [LINE_BITS-1:0]    eln;
  logic [RES_IDX_BITS-1:0] k;

  always_comb begin
    st_nxt   = st;
    hln0_nxt = hln0;
    hcl0_nxt = hcl0;
    hln1_nxt = hln1;
    hcl1_nxt = hcl1;
    n        = '0;
    k        = '0;
    do_begin = 1'b0;
    is_num   = 1'b0;
    cont     = 1'b0;
    eln      = '0;
    p        = st.pend0;
    for (int i = 0; i < MAX_RES; i++) begin
      info[i]   = '0;
      rec_ln[i] = '0;
      rec_cl[i] = '0;
    end

    unique case (st.mode)
      M_NUM, M_IDENT: begin
        is_num = (st.mode == M_NUM);
        cont   = is_num ? (is_digit(b) || b == CH_DOT)
                        : (is_alpha(b) || is_digit(b) || b == CH_US);
        k = n[RES_IDX_BITS-1:0];
        if (cont) begin
          // the held char is now known not to be the last one
          info[k]   = mk_info(is_num ? KIND_NUMBER : KIND_IDENT, p, st.held_first, 1'b0,
                              st.held_err ? ERR_SECOND_DOT : ERR_NONE);
          rec_ln[k] = hln0;
          rec_cl[k] = hcl0;
          n         = n + 1'b1;
          st_nxt.held_err   = is_num && b == CH_DOT && st.dot_seen;
          st_nxt.held_first = 1'b0;
          if (is_num && b == CH_DOT) st_nxt.dot_seen = 1'b1;
          st_nxt.pend0 = b;
          hln0_nxt     = ln;
          hcl0_nxt     = cl;
        end else begin
          info[k]   = mk_info(is_num ? KIND_NUMBER : KIND_IDENT, p, st.held_first, 1'b1,
                              close_err(is_num, st.held_err, p));
          rec_ln[k] = hln0;
          rec_cl[k] = hcl0;
          n         = n + 1'b1;
          st_nxt.mode = M_IDLE;
          do_begin    = 1'b1;
        end
      end
      M_OP1: begin
        if ((p == CH_PLUS && b == CH_PLUS) ||
            (p == CH_MINUS && (b == CH_MINUS || b == CH_GT)) ||
            (p == CH_AMP && b == CH_AMP) || (p == CH_BAR && b == CH_BAR) ||
            (p == CH_DOT && b == CH_DOT) || (b == CH_EQ && is_opchar(p) && p != CH_LT &&
             !(p == CH_SLASH && b == CH_SLASH))) begin
          info[0]   = mk_info(KIND_SYMBOL, p, 1'b1, 1'b0, ERR_NONE);
          rec_ln[0] = hln0;
          rec_cl[0] = hcl0;
          info[1]   = mk_info(KIND_SYMBOL, b, 1'b0, 1'b1, ERR_NONE);
          rec_ln[1] = ln;
          rec_cl[1] = cl;
          n         = RES_CNT_BITS'(2);
          st_nxt.mode = M_IDLE;
        end else if (p == CH_SLASH && b == CH_SLASH) begin
          st_nxt.mode = M_COMMENT;
        end else if (p == CH_LT && b == CH_EQ) begin
          // may still grow into the three-char compare
          st_nxt.pend1 = b;
          hln1_nxt     = ln;
          hcl1_nxt     = cl;
          st_nxt.mode  = M_OP2;
        end else begin
          info[0]   = mk_info(KIND_SYMBOL, p, 1'b1, 1'b1, ERR_NONE);
          rec_ln[0] = hln0;
          rec_cl[0] = hcl0;
          n         = RES_CNT_BITS'(1);
          st_nxt.mode = M_IDLE;
          do_begin    = 1'b1;
        end
      end
      M_OP2: begin
        info[0]   = mk_info(KIND_SYMBOL, p, 1'b1, 1'b0, ERR_NONE);
        rec_ln[0] = hln0;
        rec_cl[0] = hcl0;
        info[1]   = mk_info(KIND_SYMBOL, st.pend1, 1'b0, (b != CH_GT), ERR_NONE);
        rec_ln[1] = hln1;
        rec_cl[1] = hcl1;
        n         = RES_CNT_BITS'(2);
        st_nxt.mode = M_IDLE;
        if (b == CH_GT) begin
          info[2]   = mk_info(KIND_SYMBOL, b, 1'b0, 1'b1, ERR_NONE);
          rec_ln[2] = ln;
          rec_cl[2] = cl;
          n         = RES_CNT_BITS'(3);
        end else begin
          do_begin = 1'b1;
        end
      end
      M_COMMENT: begin
        if (b == CH_NL) st_nxt.mode = M_IDLE;
      end
      M_STRING: begin
        rec_ln[0] = ln;
        rec_cl[0] = cl;
        n         = RES_CNT_BITS'(1);
        if (b == CH_DQUOTE) begin
          info[0]     = mk_info(KIND_STRING, b, 1'b0, 1'b1, ERR_NONE);
          st_nxt.mode = M_IDLE;
        end else if (b == CH_NL) begin
          info[0]     = mk_info(KIND_STRING, b, 1'b0, 1'b1, ERR_UNTERMINATED);
          st_nxt.mode = M_IDLE;
        end else begin
          info[0] = mk_info(KIND_STRING, b, 1'b0, fin, fin ? ERR_UNTERMINATED : ERR_NONE);
        end
      end
      M_CHAR1: begin
        info[0]     = mk_info(KIND_CHAR, b, 1'b0, fin, fin ? ERR_UNTERMINATED : ERR_NONE);
        rec_ln[0]   = ln;
        rec_cl[0]   = cl;
        n           = RES_CNT_BITS'(1);
        st_nxt.mode = M_CHAR2;
      end
      M_CHAR2: begin
        info[0]     = mk_info(KIND_CHAR, b, 1'b0, 1'b1, ERR_NONE);
        rec_ln[0]   = ln;
        rec_cl[0]   = cl;
        n           = RES_CNT_BITS'(1);
        st_nxt.mode = M_IDLE;
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    // start of a new token with this byte
    if (do_begin) begin
      st_nxt.mode = M_IDLE;
      k = n[RES_IDX_BITS-1:0];
      if (is_digit(b) || is_alpha(b) || b == CH_US) begin
        st_nxt.mode       = is_digit(b) ? M_NUM : M_IDENT;
        st_nxt.pend0      = b;
        hln0_nxt          = ln;
        hcl0_nxt          = cl;
        st_nxt.held_first = 1'b1;
        st_nxt.held_err   = 1'b0;
        st_nxt.dot_seen   = 1'b0;
      end else if (is_opchar(b) || b == CH_AMP || b == CH_BAR || b == CH_DOT) begin
        st_nxt.mode  = M_OP1;
        st_nxt.pend0 = b;
        hln0_nxt     = ln;
        hcl0_nxt     = cl;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_NL) begin
        st_nxt.mode = M_IDLE;
      end else begin
        rec_ln[k] = ln;
        rec_cl[k] = cl;
        n         = n + 1'b1;
        if (is_single(b)) begin
          info[k] = mk_info(KIND_SYMBOL, b, 1'b1, 1'b1, ERR_NONE);
        end else if (b == CH_DQUOTE) begin
          info[k]     = mk_info(KIND_STRING, b, 1'b1, fin, fin ? ERR_UNTERMINATED : ERR_NONE);
          st_nxt.mode = M_STRING;
        end else if (b == CH_SQUOTE) begin
          info[k]     = mk_info(KIND_CHAR, b, 1'b1, fin, fin ? ERR_UNTERMINATED : ERR_NONE);
          st_nxt.mode = M_CHAR1;
        end else begin
          info[k] = mk_info(KIND_SYMBOL, b, 1'b1, 1'b1, ERR_INVALID);
        end
      end
    end

    if (b == CH_NL) begin
      ln_nxt = sat_ln(ln);
      cl_nxt = COLUMN_BITS'(1);
    end else begin
      ln_nxt = ln;
      cl_nxt = sat_cl(cl);
    end

    // end of source: flush what is held, then the end token, then back to reset
    if (fin) begin
      eln = sat_ln(ln_nxt);
      k   = n[RES_IDX_BITS-1:0];
      if (st_nxt.mode == M_NUM || st_nxt.mode == M_IDENT) begin
        is_num    = (st_nxt.mode == M_NUM);
        info[k]   = mk_info(is_num ? KIND_NUMBER : KIND_IDENT, st_nxt.pend0,
                            st_nxt.held_first, 1'b1,
                            close_err(is_num, st_nxt.held_err, st_nxt.pend0));
        rec_ln[k] = hln0_nxt;
        rec_cl[k] = hcl0_nxt;
        n         = n + 1'b1;
      end else if (st_nxt.mode == M_OP1 || st_nxt.mode == M_OP2) begin
        info[k]   = mk_info(KIND_SYMBOL, st_nxt.pend0, 1'b1, (st_nxt.mode == M_OP1),
                            ERR_NONE);
        rec_ln[k] = hln0_nxt;
        rec_cl[k] = hcl0_nxt;
        n         = n + 1'b1;
        if (st_nxt.mode == M_OP2) begin
          k         = n[RES_IDX_BITS-1:0];
          info[k]   = mk_info(KIND_SYMBOL, st_nxt.pend1, 1'b0, 1'b1, ERR_NONE);
          rec_ln[k] = hln1_nxt;
          rec_cl[k] = hcl1_nxt;
          n         = n + 1'b1;
        end
      end
      k         = n[RES_IDX_BITS-1:0];
      info[k]   = mk_info(KIND_END, 8'h00, 1'b1, 1'b1, ERR_NONE);
      rec_ln[k] = eln;
      rec_cl[k] = cl_nxt;
      n         = n + 1'b1;
      st_nxt.mode       = M_IDLE;
      st_nxt.dot_seen   = 1'b0;
      st_nxt.held_first = 1'b0;
      st_nxt.held_err   = 1'b0;
      ln_nxt            = LINE_BITS'(1);
      cl_nxt            = COLUMN_BITS'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/source_char_tokenizer_unit.sv]
// top level of the streaming source character tokenizer
`timescale 1ns / 1ps
`default_nettype none

// Takes one source byte per item and returns every token character as its own
// result, with kind, first/last marks, line, column and an error code. A byte
// is scanned in the cycle it is accepted and its results (zero to four) land in
// a four-slot result register, visible the cycle after acceptance, that drains
// one result per cycle while the output is ready. The next byte is taken once
// the register is empty or in the cycle the last result of the previous byte
// leaves, so a byte that yields several results holds the input until they
// have drained. Up to two bytes of lookahead (identifiers, numbers, operators,
// "<=") are held inside, so a character comes out when its role is known.
module source_char_tokenizer_unit #(
  parameter int LINE_BITS   = sctok_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = sctok_pkg::COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sctok_in_if.sink    in_ch,
  sctok_out_if.source out_ch
);
  import sctok_pkg::*;

  scan_state_t            st_r;
  scan_state_t            st_nxt;
  logic [LINE_BITS-1:0]   ln_r, ln_nxt;
  logic [COLUMN_BITS-1:0] cl_r, cl_nxt;
  logic [LINE_BITS-1:0]   hln0_r, hln0_nxt, hln1_r, hln1_nxt;
  logic [COLUMN_BITS-1:0] hcl0_r, hcl0_nxt, hcl1_r, hcl1_nxt;

  tok_info_t              info [MAX_RES];
  logic [LINE_BITS-1:0]   rec_ln [MAX_RES];
  logic [COLUMN_BITS-1:0] rec_cl [MAX_RES];
  logic [RES_CNT_BITS-1:0] n;

  tok_info_t              buf_info_r [MAX_RES];
  logic [LINE_BITS-1:0]   buf_ln_r [MAX_RES];
  logic [COLUMN_BITS-1:0] buf_cl_r [MAX_RES];
  logic [MAX_RES-1:0]     buf_last_r;
  logic [RES_CNT_BITS-1:0] cnt_r;

  logic accept;
  logic pop;

  sctok_step #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_step (
    .b        (in_ch.source_byte),
    .fin      (in_ch.end_of_source),
    .st       (st_r),
    .ln       (ln_r),
    .cl       (cl_r),
    .hln0     (hln0_r),
    .hcl0     (hcl0_r),
    .hln1     (hln1_r),
    .hcl1     (hcl1_r),
    .st_nxt   (st_nxt),
    .ln_nxt   (ln_nxt),
    .cl_nxt   (cl_nxt),
    .hln0_nxt (hln0_nxt),
    .hcl0_nxt (hcl0_nxt),
    .hln1_nxt (hln1_nxt),
    .hcl1_nxt (hcl1_nxt),
    .info     (info),
    .rec_ln   (rec_ln),
    .rec_cl   (rec_cl),
    .n        (n)
  );

  // new item once the result register is empty or its last result is leaving
  assign in_ch.ready = (cnt_r == '0) || (cnt_r == RES_CNT_BITS'(1) && out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  // an all-zero state is the idle mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      ln_r       <= LINE_BITS'(1);
      cl_r       <= COLUMN_BITS'(1);
    end else if (accept) begin
      st_r <= st_nxt;
      ln_r <= ln_nxt;
      cl_r <= cl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hln0_r <= hln0_nxt;
      hcl0_r <= hcl0_nxt;
      hln1_r <= hln1_nxt;
      hcl1_r <= hcl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= n;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_info_r[i] <= info[i];
        buf_ln_r[i]   <= rec_ln[i];
        buf_cl_r[i]   <= rec_cl[i];
        buf_last_r[i] <= (n == RES_CNT_BITS'(i + 1));
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_info_r[i] <= buf_info_r[i + 1];
        buf_ln_r[i]   <= buf_ln_r[i + 1];
        buf_cl_r[i]   <= buf_cl_r[i + 1];
        buf_last_r[i] <= buf_last_r[i + 1];
      end
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.token_kind    = buf_info_r[0].kind;
  assign out_ch.token_byte    = buf_info_r[0].chr;
  assign out_ch.token_first   = buf_info_r[0].first;
  assign out_ch.token_last    = buf_info_r[0].last;
  assign out_ch.error_code    = buf_info_r[0].err;
  assign out_ch.line_number   = buf_ln_r[0];
  assign out_ch.column_number = buf_cl_r[0];
  assign out_ch.run_last      = buf_last_r[0];

endmodule

`default_nettype wire

[rtl/sctok_checker.sv]
// port-level assertions for the tokenizer and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module sctok_checker #(
  parameter int LINE_BITS = sctok_pkg::LINE_BITS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           token_kind,
  input wire logic                 token_first,
  input wire logic                 token_last,
  input wire logic [LINE_BITS-1:0] line_number,
  input wire logic                 run_last
);
  import sctok_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // results of one item leave back to back
  a_run_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside the results of one item");

  // no new item while more results of the current one are waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> !in_ready)
    else $error("input taken before earlier item drained");

  // end token is a whole token and closes its item
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == KIND_END |-> token_first && token_last && run_last)
    else $error("malformed end token");

  // lines start at one
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_number != '0)
    else $error("line number zero");

endmodule

bind source_char_tokenizer_unit sctok_checker #(
  .LINE_BITS (LINE_BITS)
) u_sctok_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .token_kind  (out_ch.token_kind),
  .token_first (out_ch.token_first),
  .token_last  (out_ch.token_last),
  .line_number (out_ch.line_number),
  .run_last    (out_ch.run_last)
);

`default_nettype wire
